[hdl/char_range_expander_macros.svh]
// Assertion macros shared by the character range expander modules.
// No dependencies; included by the modules that carry assertions.
`ifndef CHAR_RANGE_EXPANDER_MACROS_SVH
`define CHAR_RANGE_EXPANDER_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define CRE_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Check a property on every rising clock edge, reset included.
`define CRE_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[hdl/cre_pkg.sv]
// Shared types and constants for the character range expander.
// No dependencies; used by the front end, the job queue and the back end.
package cre_pkg;

  // Default number of entries in the job queue
  localparam int unsigned QueueDepth = 2;

  // One emission job: an optional run lo..hi, then up to two extra characters
  typedef struct packed {
    logic       rng;
    logic [7:0] lo;
    logic [7:0] hi;
    logic [7:0] x0;
    logic [7:0] x1;
    logic [1:0] nx;
    logic       eot;
  } job_t;

  // Queue occupancy flags seen by the front and back ends
  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

endpackage

[hdl/char_range_expander.sv]
// Character range expander: expands shorthand such as a-e into abcde.
// One result leaves per cycle through a registered output, unless the output
// stalls or the back end loads its next job, once the last job is done. The
// front end and back end are parted by a short job queue (cre_queue). An item
// passes the queue entry, the back end's job registers and the output register.
// Reset clears the window, the queue and the output valid; no clearing pass.
module char_range_expander #(
  parameter int unsigned QueueDepth = cre_pkg::QueueDepth
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [7:0] in_char
  input  logic       s_axis_tlast,   // end_of_text
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,   // [7:0] out_char
  output logic       m_axis_tlast,   // run_last
  output logic [0:0] m_axis_tuser    // [0] text_done
);

  cre_pkg::queue_status_t q_status;
  cre_pkg::job_t          push_job;
  cre_pkg::job_t          head_job;
  logic                   push;
  logic                   pop;

  // Classify incoming characters into jobs
  cre_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .q_status_i    (q_status),
    .push_o        (push),
    .job_o         (push_job)
  );

  // Hold pending jobs
  cre_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .job_i    (push_job),
    .pop_i    (pop),
    .job_o    (head_job),
    .status_o (q_status)
  );

  // Emit one character per cycle while the output is not stalled
  cre_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .job_i         (head_job),
    .q_status_i    (q_status),
    .pop_o         (pop),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
  );

endmodule

[hdl/cre_front.sv]
// Front end of the character range expander: input handshake, two-character
// window and classification of each item into an emission job. Uses cre_pkg.
module cre_front (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [7:0]             s_axis_tdata,   // [7:0] in_char
  input  logic                   s_axis_tlast,   // end_of_text
  input  cre_pkg::queue_status_t q_status_i,
  output logic                   push_o,
  output cre_pkg::job_t          job_o
);

  localparam logic [7:0] CharLowA  = 8'h61;
  localparam logic [7:0] CharLowZ  = 8'h7a;
  localparam logic [7:0] CharUpA   = 8'h41;
  localparam logic [7:0] CharUpZ   = 8'h5a;
  localparam logic [7:0] CharDig0  = 8'h30;
  localparam logic [7:0] CharDig9  = 8'h39;
  localparam logic [7:0] CharDash  = 8'h2d;

  // True when both characters are lowercase, both uppercase or both digits
  function automatic logic same_class(input logic [7:0] x, input logic [7:0] y);
    logic lo_x, lo_y, up_x, up_y, dg_x, dg_y;
    lo_x = (x >= CharLowA) && (x <= CharLowZ);
    lo_y = (y >= CharLowA) && (y <= CharLowZ);
    up_x = (x >= CharUpA) && (x <= CharUpZ);
    up_y = (y >= CharUpA) && (y <= CharUpZ);
    dg_x = (x >= CharDig0) && (x <= CharDig9);
    dg_y = (y >= CharDig0) && (y <= CharDig9);
    return (lo_x && lo_y) || (up_x && up_y) || (dg_x && dg_y);
  endfunction

  logic [7:0] older_char_q, older_char_d;
  logic       older_valid_q, older_valid_d;
  logic [7:0] newer_char_q, newer_char_d;
  logic       newer_valid_q, newer_valid_d;

  logic accept;
  logic is_range;
  cre_pkg::job_t job;

  assign s_axis_tready = !q_status_i.full;
  assign accept        = s_axis_tvalid && s_axis_tready;

  // Classify the incoming character against the window
  always_comb begin
    is_range = older_valid_q && newer_valid_q && (newer_char_q == CharDash) &&
               same_class(older_char_q, s_axis_tdata);
    job      = '0;
    job.eot  = s_axis_tlast;
    if (is_range) begin
      job.rng = (s_axis_tdata >= older_char_q);
      job.lo  = older_char_q;
      job.hi  = s_axis_tdata;
      job.nx  = 2'd0;
    end else begin
      job.rng = older_valid_q;
      job.lo  = older_char_q;
      job.hi  = older_char_q;
      job.x0  = newer_valid_q ? newer_char_q : s_axis_tdata;
      job.x1  = s_axis_tdata;
      if (s_axis_tlast) begin
        job.nx = newer_valid_q ? 2'd2 : 2'd1;
      end else begin
        job.nx = 2'd0;
      end
    end
  end

  // Drop jobs that emit nothing (descending ranges, characters that only fill the window)
  assign push_o = accept && (job.rng || (job.nx != 2'd0));
  assign job_o  = job;

  // Shift the window, or empty it on a range or at the end of the text
  always_comb begin
    older_char_d  = older_char_q;
    older_valid_d = older_valid_q;
    newer_char_d  = newer_char_q;
    newer_valid_d = newer_valid_q;
    if (accept) begin
      if (is_range || s_axis_tlast) begin
        older_char_d  = '0;
        older_valid_d = 1'b0;
        newer_char_d  = '0;
        newer_valid_d = 1'b0;
      end else begin
        older_char_d  = newer_char_q;
        older_valid_d = newer_valid_q;
        newer_char_d  = s_axis_tdata;
        newer_valid_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      older_char_q  <= '0;
      older_valid_q <= 1'b0;
      newer_char_q  <= '0;
      newer_valid_q <= 1'b0;
    end else begin
      older_char_q  <= older_char_d;
      older_valid_q <= older_valid_d;
      newer_char_q  <= newer_char_d;
      newer_valid_q <= newer_valid_d;
    end
  end

endmodule

[hdl/cre_queue.sv]
// Job queue between the front and back ends of the character range expander.
// Small circular buffer of cre_pkg::job_t entries.
`include "char_range_expander_macros.svh"

module cre_queue #(
  parameter int unsigned Depth = cre_pkg::QueueDepth
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   push_i,
  input  cre_pkg::job_t          job_i,
  input  logic                   pop_i,
  output cre_pkg::job_t          job_o,
  output cre_pkg::queue_status_t status_o
);

  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW  = $clog2(Depth + 1);
  localparam logic [AddrW-1:0] LastAddr = AddrW'(Depth - 1);
  localparam logic [CntW-1:0]  FullCnt  = CntW'(Depth);

  cre_pkg::job_t mem_q [Depth];

  logic [AddrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [AddrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  count_q, count_d;
  logic             do_push, do_pop;

  assign status_o.full  = (count_q == FullCnt);
  assign status_o.empty = (count_q == '0);
  assign do_push = push_i && !status_o.full;
  assign do_pop  = pop_i && !status_o.empty;
  assign job_o   = mem_q[rd_ptr_q];

  // Advance pointers with wrap and track occupancy
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == LastAddr) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == LastAddr) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Store the pushed job
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= job_i;
    end
  end

  `CRE_ASSERT(a_no_push_full, clk_i, rst_ni, push_i |-> !status_o.full, "push into full queue")
  `CRE_ASSERT(a_count_bound, clk_i, rst_ni, count_q <= FullCnt, "queue count beyond depth")

endmodule

[hdl/cre_back.sv]
// Back end of the character range expander: pops jobs, walks each run and
// extra characters one per cycle, unless the output stalls, into the output register. Uses cre_pkg.
`include "char_range_expander_macros.svh"

module cre_back (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  cre_pkg::job_t          job_i,
  input  cre_pkg::queue_status_t q_status_i,
  output logic                   pop_o,
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [7:0]             m_axis_tdata,   // [7:0] out_char
  output logic                   m_axis_tlast,   // run_last
  output logic [0:0]             m_axis_tuser    // [0] text_done
);

  logic       rng_q, rng_d;
  logic [7:0] cur_q, cur_d;
  logic [7:0] hi_q, hi_d;
  logic [7:0] x0_q, x0_d;
  logic [7:0] x1_q, x1_d;
  logic [1:0] nx_q, nx_d;
  logic       eot_q, eot_d;

  logic       out_valid_q, out_valid_d;
  logic [7:0] out_char_q, out_char_d;
  logic       out_last_q, out_last_d;
  logic       out_done_q, out_done_d;

  logic busy, adv, emit, last_c;

  assign busy   = rng_q || (nx_q != 2'd0);
  assign adv    = !out_valid_q || m_axis_tready;
  assign emit   = busy && adv;
  assign pop_o  = !busy && !q_status_i.empty;
  assign last_c = rng_q ? ((cur_q == hi_q) && (nx_q == 2'd0)) : (nx_q == 2'd1);

  // Load a job, or step through the run and then the extra characters
  always_comb begin
    rng_d       = rng_q;
    cur_d       = cur_q;
    hi_d        = hi_q;
    x0_d        = x0_q;
    x1_d        = x1_q;
    nx_d        = nx_q;
    eot_d       = eot_q;
    out_valid_d = out_valid_q;
    out_char_d  = out_char_q;
    out_last_d  = out_last_q;
    out_done_d  = out_done_q;
    if (pop_o) begin
      rng_d = job_i.rng;
      cur_d = job_i.lo;
      hi_d  = job_i.hi;
      x0_d  = job_i.x0;
      x1_d  = job_i.x1;
      nx_d  = job_i.nx;
      eot_d = job_i.eot;
    end
    if (emit) begin
      out_valid_d = 1'b1;
      out_last_d  = last_c;
      out_done_d  = last_c && eot_q;
      if (rng_q) begin
        out_char_d = cur_q;
        if (cur_q == hi_q) begin
          rng_d = 1'b0;
        end else begin
          cur_d = cur_q + 1'b1;
        end
      end else begin
        out_char_d = x0_q;
        x0_d       = x1_q;
        nx_d       = nx_q - 1'b1;
      end
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rng_q       <= 1'b0;
      nx_q        <= 2'd0;
      eot_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      rng_q       <= rng_d;
      nx_q        <= nx_d;
      eot_q       <= eot_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Job payload and output data need no reset
  always_ff @(posedge clk_i) begin
    cur_q      <= cur_d;
    hi_q       <= hi_d;
    x0_q       <= x0_d;
    x1_q       <= x1_d;
    out_char_q <= out_char_d;
    out_last_q <= out_last_d;
    out_done_q <= out_done_d;
  end

  assign m_axis_tvalid   = out_valid_q;
  assign m_axis_tdata    = out_char_q;
  assign m_axis_tlast    = out_last_q;
  assign m_axis_tuser[0] = out_done_q;

  `CRE_ASSERT(a_run_in_bounds, clk_i, rst_ni, rng_q |-> (cur_q <= hi_q), "run walked past its end")
  `CRE_ASSERT(a_done_is_last, clk_i, rst_ni, (m_axis_tvalid && m_axis_tuser[0]) |-> m_axis_tlast, "text end off job end")
  `CRE_ASSERT(a_idle_after_last, clk_i, rst_ni, (emit && last_c) |=> !busy, "job still busy after its last result")

endmodule
